/* hdl/ttag_pkg.sv */
// Shared types and constants of the tensor transpose address generator.
// Used by the configuration block, the divide cells and the top level.
`timescale 1ns / 1ps
package ttag_pkg;
	localparam int IDX_W  = 32;
	localparam int DIM_W  = 16;
	localparam int DIMS   = 4;
	localparam int PROD_W = IDX_W + 1;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	localparam logic [1:0] REG_RANK  = 2'd0;
	localparam logic [1:0] REG_SHAPE = 2'd1;
	localparam logic [1:0] REG_AXIS  = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_SHAPE = 2'd2;

	localparam logic [2:0]        RANK_RST  = 3'd2;
	localparam logic [DATA_W-1:0] SHAPE_RST = 64'h0001_0001_0001_0001;
	localparam logic [7:0]        AXIS_RST  = 8'hE1;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] rem;
		logic [IDX_W-1:0] num;
		logic [IDX_W-1:0] acc;
	} word_t;

	typedef struct packed {
		logic [IDX_W-1:0] div;
		logic             skip;
		logic [IDX_W-1:0] sstride;
	} axis_ctl_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] src;
	} result_t;
endpackage

/* hdl/ttag_cfg.sv */
// Register file and derived strides of the transpose address generator.
// Depends on ttag_pkg; feeds per-axis divisor and stride to the cell chain.
`timescale 1ns / 1ps
module ttag_cfg #(
	parameter int NAXES = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [1:0]                           wr_sel,
	input  logic [ttag_pkg::DATA_W-1:0]          wr_data,
	input  logic [1:0]                           rd_sel,
	output logic [ttag_pkg::DATA_W-1:0]          rd_data,
	output ttag_pkg::axis_ctl_t                  ctl [NAXES],
	output logic [ttag_pkg::PROD_W-1:0]          otot,
	output logic [ttag_pkg::PROD_W-1:0]          stot
);
	import ttag_pkg::*;

	logic [2:0]        rank_q;
	logic [DATA_W-1:0] shape_q;
	logic [7:0]        order_q;

	logic [2:0]        reff_q;
	logic [1:0]        perm_q [NAXES];
	logic [DIM_W-1:0]  oe_q   [NAXES];
	logic [DIM_W-1:0]  se_q   [NAXES];
	logic              act_q  [NAXES];
	logic [PROD_W-1:0] oprod_q [NAXES];
	logic [PROD_W-1:0] sprod_q [NAXES];
	axis_ctl_t         ctl_q  [NAXES];

	function automatic logic [PROD_W-1:0] sat_mul(input logic [PROD_W-1:0] a,
		input logic [DIM_W-1:0] b);
		logic [PROD_W+DIM_W-1:0] p;
		p = (PROD_W+DIM_W)'(a) * (PROD_W+DIM_W)'(b);
		return (|p[PROD_W+DIM_W-1:PROD_W]) ? {1'b1, {IDX_W{1'b0}}} : p[PROD_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q  <= RANK_RST;
			shape_q <= SHAPE_RST;
			order_q <= AXIS_RST;
		end else if (wr_en) begin
			case (wr_sel)
				REG_RANK:  rank_q  <= wr_data[2:0];
				REG_SHAPE: shape_q <= wr_data;
				REG_AXIS:  order_q <= wr_data[7:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (rd_sel)
			REG_RANK:  rd_data = DATA_W'(rank_q);
			REG_SHAPE: rd_data = shape_q;
			REG_AXIS:  rd_data = DATA_W'(order_q);
			default:   rd_data = '0;
		endcase
	end

	// effective rank, clamped permutation and per-axis sizes
	always_ff @(posedge clk) begin
		logic [2:0] r;
		logic [1:0] p;
		r = (rank_q == 3'd0) ? 3'd1 : (rank_q > 3'(NAXES)) ? 3'(NAXES) : rank_q;
		reff_q <= r;
		for (int i = 0; i < NAXES; i++) begin
			p = order_q[2*i +: 2];
			if (3'(p) >= r)
				p = 2'(r - 3'd1);
			perm_q[i] <= p;
			act_q[i]  <= (3'(i) < r);
			oe_q[i]   <= (3'(i) < r) ? shape_q[DIM_W*p +: DIM_W] : DIM_W'(1);
			se_q[i]   <= (3'(i) < r) ? shape_q[DIM_W*i +: DIM_W] : DIM_W'(1);
		end
	end

	// suffix products settle one axis per cycle
	genvar k;
	generate
		for (k = 0; k < NAXES; k++) begin : g_prod
			if (k == NAXES - 1) begin : g_last
				always_ff @(posedge clk) begin
					oprod_q[k] <= PROD_W'(oe_q[k]);
					sprod_q[k] <= PROD_W'(se_q[k]);
				end
			end else begin : g_mid
				always_ff @(posedge clk) begin
					oprod_q[k] <= sat_mul(oprod_q[k+1], oe_q[k]);
					sprod_q[k] <= sat_mul(sprod_q[k+1], se_q[k]);
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		logic [IDX_W-1:0] d;
		logic [IDX_W-1:0] ss;
		for (int i = 0; i < NAXES; i++) begin
			d  = (i == NAXES - 1) ? IDX_W'(1) : oprod_q[(i+1) % NAXES][IDX_W-1:0];
			ss = '0;
			for (int a = 0; a < NAXES; a++) begin
				if (perm_q[i] == 2'(a))
					ss = (a == NAXES - 1) ? IDX_W'(1) : sprod_q[(a+1) % NAXES][IDX_W-1:0];
			end
			ctl_q[i].div     <= d;
			ctl_q[i].skip    <= !act_q[i] || (d == '0) || (reff_q == 3'd0);
			ctl_q[i].sstride <= ss;
		end
	end

	assign ctl  = ctl_q;
	assign otot = oprod_q[0];
	assign stot = sprod_q[0];
endmodule

/* hdl/ttag_cell.sv */
// One quotient bit of an output coordinate, with source index accumulation.
// Depends on ttag_pkg; chained 32 per axis by the top level.
`timescale 1ns / 1ps
module ttag_cell #(
	parameter int BIT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  ttag_pkg::word_t     in_word,
	input  ttag_pkg::axis_ctl_t ctl,
	output logic                out_vld,
	output ttag_pkg::word_t     out_word
);
	import ttag_pkg::*;

	logic             vld_q;
	word_t            data_q;
	logic [IDX_W:0]   t;
	logic             take;
	word_t            nxt;

	always_comb begin
		t    = {in_word.rem, in_word.num[IDX_W-1]};
		take = !ctl.skip && (t >= {1'b0, ctl.div});
		nxt  = in_word;
		nxt.num = in_word.num << 1;
		nxt.rem = take ? IDX_W'(t - {1'b0, ctl.div}) : t[IDX_W-1:0];
		if (take)
			nxt.acc = in_word.acc + (ctl.sstride << BIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			data_q <= nxt;
	end

	assign out_vld  = vld_q;
	assign out_word = data_q;
endmodule

/* hdl/ttag_obuf.sv */
// Two-word output buffer that decouples the cell chain from the consumer.
// Depends on ttag_pkg for the result word layout.
`timescale 1ns / 1ps
module ttag_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ttag_pkg::result_t push_data,
	output logic              full,
	output logic              m_valid,
	input  logic              m_ready,
	output ttag_pkg::result_t m_data
);
	import ttag_pkg::*;

	result_t    e0_q, e1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop = (cnt_q != 2'd0) && m_ready;

	// push only arrives while fewer than two words are held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b11: begin
				if (cnt_q == 2'd1)
					e0_q <= push_data;
				else begin
					e0_q <= e1_q;
					e1_q <= push_data;
				end
			end
			2'b10: begin
				if (cnt_q == 2'd0)
					e0_q <= push_data;
				else
					e1_q <= push_data;
			end
			2'b01:   e0_q <= e1_q;
			default: ;
		endcase
	end

	assign full    = (cnt_q == 2'd2);
	assign m_valid = (cnt_q != 2'd0);
	assign m_data  = e0_q;
endmodule

/* hdl/tensor_transpose_address_gen_top.sv */
// Pipeline: NAXES+3 lead stages, 32 cells per axis, then the two-word output buffer.
// Throughput: one word per cycle; each cell retires one quotient bit of one coordinate.
// The chain stalls only when the two-word output buffer is full.
// Reset clears registers to rank 2, sizes 1, order 1,0,2,3 and empties the chain.
// After a register write, derived strides settle while words wait in the lead stages.
`timescale 1ns / 1ps
module tensor_transpose_address_gen_top #(
	parameter int MAX_RANK = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ttag_pkg::ADDR_W-1:0]   paddr,
	input  logic [ttag_pkg::DATA_W-1:0]   pwdata,
	output logic [ttag_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,  // out_index[31:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata   // src_index[31:0], status[33:32], zero
);
	import ttag_pkg::*;

	localparam int NAXES = (MAX_RANK < DIMS) ? MAX_RANK : DIMS;
	localparam int LEAD  = NAXES + 3;
	localparam int NCELL = NAXES * IDX_W;

	axis_ctl_t         ctl [NAXES];
	logic [PROD_W-1:0] otot, stot;
	logic              en, full;
	logic              lead_vld_q [LEAD];
	logic [IDX_W-1:0]  lead_idx_q [LEAD];
	logic              cv [NCELL+1];
	word_t             cw [NCELL+1];
	result_t           res, m_res;

	assign pready = 1'b1;

	ttag_cfg #(.NAXES(NAXES)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (psel && penable && pwrite),
		.wr_sel  (paddr[4:3]),
		.wr_data (pwdata),
		.rd_sel  (paddr[4:3]),
		.rd_data (prdata),
		.ctl     (ctl),
		.otot    (otot),
		.stot    (stot)
	);

	assign en       = !full;
	assign s_tready = en;

	// hold words until the derived strides are valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEAD; i++)
				lead_vld_q[i] <= 1'b0;
		end else if (en) begin
			lead_vld_q[0] <= s_tvalid;
			for (int i = 1; i < LEAD; i++)
				lead_vld_q[i] <= lead_vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lead_idx_q[0] <= s_tdata;
			for (int i = 1; i < LEAD; i++)
				lead_idx_q[i] <= lead_idx_q[i-1];
		end
	end

	assign cv[0]     = lead_vld_q[LEAD-1];
	assign cw[0].idx = lead_idx_q[LEAD-1];
	assign cw[0].rem = '0;
	assign cw[0].num = lead_idx_q[LEAD-1];
	assign cw[0].acc = '0;

	genvar a, j;
	generate
		for (a = 0; a < NAXES; a++) begin : g_axis
			for (j = 0; j < IDX_W; j++) begin : g_bit
				word_t w_in;
				if (j == 0 && a > 0) begin : g_seam
					// remainder of the previous axis becomes the next dividend
					always_comb begin
						w_in     = cw[a*IDX_W];
						w_in.num = cw[a*IDX_W].rem;
						w_in.rem = '0;
					end
				end else begin : g_pass
					assign w_in = cw[a*IDX_W + j];
				end
				ttag_cell #(.BIT(IDX_W - 1 - j)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.en       (en),
					.in_vld   (cv[a*IDX_W + j]),
					.in_word  (w_in),
					.ctl      (ctl[a]),
					.out_vld  (cv[a*IDX_W + j + 1]),
					.out_word (cw[a*IDX_W + j + 1])
				);
			end
		end
	endgenerate

	always_comb begin
		if (otot[IDX_W] || stot[IDX_W]) begin
			res.status = STATUS_SHAPE;
			res.src    = '0;
		end else if ({1'b0, cw[NCELL].idx} >= otot) begin
			res.status = STATUS_RANGE;
			res.src    = '0;
		end else begin
			res.status = STATUS_OK;
			res.src    = cw[NCELL].acc;
		end
	end

	ttag_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cv[NCELL] && en),
		.push_data (res),
		.full      (full),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_data    (m_res)
	);

	assign m_tdata = {6'b0, m_res.status, m_res.src};
endmodule

/* hdl/ttag_check.sv */
// Port-level checks of the transpose address generator, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module ttag_check (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'd3)
		else $error("undefined status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] != 2'd0 |-> m_tdata[31:0] == 32'd0)
		else $error("source index not cleared on error");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] == 6'd0 && pready)
		else $error("padding bits set or port not ready");
endmodule

bind tensor_transpose_address_gen_top ttag_check u_chk (.*);

/* tb/tb_tensor_transpose_address_gen_top.sv */
// Self-checking bench for the tensor transpose address generator.
// Predicts each source index and status from the APB settings; needs ttag_pkg and the top level.
`timescale 1ns / 1ps
module tb_tensor_transpose_address_gen_top;
	import ttag_pkg::*;

	localparam int LIMIT_CYCLES = 900000;

	typedef struct {
		logic [IDX_W-1:0] src;
		logic [1:0]       status;
	} addr_word_t;

	class transpose_scoreboard;
		logic [2:0]        rank;
		logic [DATA_W-1:0] sizes;
		logic [7:0]        order;
		addr_word_t        pending[$];
		int                errors;

		function new();
			rank = RANK_RST;
			sizes = SHAPE_RST;
			order = AXIS_RST;
			errors = 0;
		endfunction

		function longint unsigned dim_of(int a);
			return longint'(sizes[16*a +: 16]);
		endfunction

		function void note_index(logic [IDX_W-1:0] idx);
			int r;
			int p[4];
			longint unsigned osz[4], sst[4], dst[4];
			longint unsigned otot, stot, rem, c;
			logic [IDX_W-1:0] acc;
			addr_word_t w;
			r = int'(rank);
			if (r < 1) r = 1;
			if (r > 4) r = 4;
			otot = 1;
			stot = 1;
			for (int i = 0; i < r; i++) begin
				p[i] = int'(order[2*i +: 2]);
				if (p[i] >= r) p[i] = r - 1;
				osz[i] = dim_of(p[i]);
				otot = otot * osz[i];
				stot = stot * dim_of(i);
			end
			w.src = '0;
			if (otot >= 64'h1_0000_0000 || stot >= 64'h1_0000_0000) begin
				w.status = STATUS_SHAPE;
			end else if (longint'(idx) >= otot) begin
				w.status = STATUS_RANGE;
			end else begin
				w.status = STATUS_OK;
				sst[r-1] = 1;
				dst[r-1] = 1;
				for (int d = r - 2; d >= 0; d--) begin
					sst[d] = sst[d+1] * dim_of(d + 1);
					dst[d] = dst[d+1] * osz[d+1];
				end
				rem = 64'(idx);
				acc = '0;
				for (int i = 0; i < r; i++) begin
					c = 0;
					if (dst[i] != 0) begin
						c = rem / dst[i];
						rem = rem % dst[i];
					end
					acc = acc + IDX_W'(c * sst[p[i]]);
				end
				w.src = acc;
			end
			pending.insert(pending.size(), w);
		endfunction

		function void check_word(logic [39:0] data);
			addr_word_t w;
			if (pending.size() == 0) begin
				$error("unexpected word %h", data);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (data[31:0] !== w.src) begin
				$error("src_index expected %h actual %h", w.src, data[31:0]);
				errors++;
			end
			if (data[33:32] !== w.status) begin
				$error("status expected %0d actual %0d", w.status, data[33:32]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [39:0] m_tdata;

	transpose_scoreboard sb;
	int cycles = 0;

	always #1 clk = ~clk;

	tensor_transpose_address_gen_top dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	// Drop results into the checker and stall the receiver at random.
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_word(m_tdata);
			if (m_tvalid && m_tready || !m_tready) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
				if (($urandom & 1) && gap > 0) begin
					m_tready <= 0;
					repeat (gap) begin
						@(posedge clk);
					end
					m_tready <= 1;
				end else begin
					m_tready <= 1;
				end
			end
		end
	end

	task automatic write_reg(logic [1:0] which, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'(which) << 3;
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (which)
			REG_RANK: sb.rank = value[2:0];
			REG_SHAPE: sb.sizes = value;
			default: sb.order = value[7:0];
		endcase
	endtask

	task automatic send_index(logic [31:0] idx, bit burst);
		int gap;
		if (burst)
			gap = ($urandom_range(0, 7) == 0) ? 1 : 0;
		else
			gap = $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= idx;
		do @(posedge clk); while (!s_tready);
		sb.note_index(idx);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand_sizes(int maxd);
		logic [DATA_W-1:0] v;
		for (int i = 0; i < 4; i++) v[16*i +: 16] = 16'($urandom_range(1, maxd));
		return v;
	endfunction

	function automatic logic [7:0] rand_perm();
		int a[4] = '{0, 1, 2, 3};
		int j, t;
		for (int i = 3; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = a[i]; a[i] = a[j]; a[j] = t;
		end
		return {2'(a[3]), 2'(a[2]), 2'(a[1]), 2'(a[0])};
	endfunction

	function automatic logic [31:0] rand_index();
		int k = $urandom_range(0, 9);
		if (k < 7) return $urandom_range(0, 700);
		if (k < 9) return $urandom_range(0, 70000);
		return $urandom;
	endfunction

	initial begin
		bit burst;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Reset shape: every index above zero is out of range.
		send_index(0, 1'b0);
		send_index(1, 1'b0);
		send_index(32'hFFFF_FFFF, 1'b0);
		drain();
		write_reg(REG_SHAPE, {16'd1, 16'd1, 16'd3, 16'd4});
		send_index(0, 1'b0);
		send_index(5, 1'b0);
		send_index(11, 1'b0);
		send_index(12, 1'b0);
		drain();
		write_reg(REG_RANK, DATA_W'(3'd0));
		send_index(3, 1'b0);
		drain();
		write_reg(REG_RANK, DATA_W'(3'd7));
		write_reg(REG_AXIS, DATA_W'(8'hFF));
		write_reg(REG_SHAPE, {16'd2, 16'd3, 16'd4, 16'd5});
		for (int i = 0; i < 4; i++) send_index(i * 37, 1'b0);
		drain();
		write_reg(REG_AXIS, DATA_W'(8'h1B));
		write_reg(REG_SHAPE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_index(0, 1'b0);
		drain();
		write_reg(REG_RANK, DATA_W'(3'd2));
		send_index(32'hFFFE_0000, 1'b0);
		send_index(32'hFFFE_0001, 1'b0);
		drain();
		write_reg(REG_SHAPE, {16'd7, 16'd0, 16'd9, 16'd3});
		send_index(0, 1'b0);
		drain();
		write_reg(REG_RANK, DATA_W'(3'd4));
		send_index(2, 1'b0);
		drain();
		for (int ph = 0; ph < 22; ph++) begin
			write_reg(REG_RANK, DATA_W'($urandom_range(0, 9) == 0 ? 3'($urandom)
				: 3'($urandom_range(1, 4))));
			write_reg(REG_SHAPE, $urandom_range(0, 7) == 0 ? {$urandom, $urandom}
				: rand_sizes($urandom_range(0, 1) ? 6 : 40));
			write_reg(REG_AXIS, DATA_W'($urandom_range(0, 4) == 0 ? 8'($urandom)
				: rand_perm()));
			burst = $urandom_range(0, 2) == 0;
			for (int n = 0; n < 50; n++) send_index(rand_index(), burst);
			if (ph == 10) begin
				s_tvalid <= 0;
				while (sb.pending.size() != 0) @(posedge clk);
			end
			drain();
		end
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
